// ===== hdl/kts_pkg.sv =====
`default_nettype none

package kts_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NCHAN       = 5;

  localparam int CFG_W     = VALUE_WIDTH - 1;
  localparam int CFG_IDX_W = 1;
  localparam int K_W       = FRAC_BITS + 1;
  localparam int DEN_W     = VALUE_WIDTH + 1;
  localparam int MUL_A_W   = VALUE_WIDTH + 1;
  localparam int MUL_P_W   = MUL_A_W + K_W + 1;
  localparam int WIDE_W    = VALUE_WIDTH + 4;
  localparam int CH_W      = $clog2(NCHAN);
  localparam int TDATA_W   = ((NCHAN * VALUE_WIDTH + 7) / 8) * 8;

  localparam logic [K_W-1:0]         K_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CFG_W-1:0]       Q_RESET = CFG_W'(((64'd4 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [CFG_W-1:0]       R_RESET = CFG_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [VALUE_WIDTH-1:0] P_RESET = VALUE_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic [VALUE_WIDTH-1:0] V_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] V_MIN   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEAS_NOISE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] num;
    logic [DEN_W-1:0]       den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [K_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [WIDE_W-1:0] sext_w(input logic [VALUE_WIDTH-1:0] v);
    sext_w = {{(WIDE_W-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
  endfunction

  // clamp to the signed value range
  function automatic logic [VALUE_WIDTH-1:0] sat_v(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (&v[WIDE_W-1:VALUE_WIDTH-1]) || !(|v[WIDE_W-1:VALUE_WIDTH-1]);
    if (fits) begin
      sat_v = v[VALUE_WIDTH-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_v = V_MIN;
    end else begin
      sat_v = V_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kalman_trajectory_smoother.sv =====
// Each accepted word runs through every channel before out_tvalid rises; on the first
//   frame after reset no gain is worked out. A new word is taken only once the result
//   of the last one has been loaded into the output register; each
//   channel runs the gain divider (one quotient bit a cycle), then two multiplier passes.
// Reset (rst_n low, synchronous): trajectory sums and estimates 0, covariances 1.0,
//   Q = 0.004, R = 0.5, first-frame flag set, no result pending.
`default_nettype none

module kalman_trajectory_smoother import kts_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // motion deltas, low bit up: delta_trans_x, delta_trans_y, delta_angle,
  // delta_scale_x, delta_scale_y (signed Q16.16 each)
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [TDATA_W-1:0]   in_tdata,
  // smoothed motion, low bit up: smooth_trans_x, smooth_trans_y, smooth_angle,
  // smooth_scale_x, smooth_scale_y (signed Q16.16 each)
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [TDATA_W-1:0]        out_tdata,
  // register write: 0 process noise Q, 1 measurement noise R
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Sequencer: per channel, SUM -> (KICK -> DIVW -> MUL1 -> MUL2 -> MUL3) -> RES;
  // the bracketed part is skipped on the first frame.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SUM  = 9'b000000010,
    S_KICK = 9'b000000100,
    S_DIVW = 9'b000001000,
    S_MUL1 = 9'b000010000,
    S_MUL2 = 9'b000100000,
    S_MUL3 = 9'b001000000,
    S_RES  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            first_r;

  // config
  logic [CFG_W-1:0] q_r;
  logic [CFG_W-1:0] r_r;

  // per-channel filter state
  logic [VALUE_WIDTH-1:0] sum_r   [NCHAN];
  logic [VALUE_WIDTH-1:0] est_r   [NCHAN];
  logic [VALUE_WIDTH-1:0] cov_r   [NCHAN];
  logic [VALUE_WIDTH-1:0] delta_r [NCHAN];
  logic [VALUE_WIDTH-1:0] res_r   [NCHAN];

  // per-channel working values
  logic [VALUE_WIDTH-1:0] pp_r;
  logic [K_W-1:0]         k_r;

  logic                 out_tvalid_r;
  logic [TDATA_W-1:0]   out_tdata_r;

  logic [VALUE_WIDTH-1:0] sum_cur, est_cur, cov_cur, delta_cur;
  logic [VALUE_WIDTH-1:0] sum_add;
  logic [VALUE_WIDTH:0]   pp_raw;
  logic [VALUE_WIDTH-1:0] pp_sat;
  logic signed [MUL_A_W-1:0] diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [K_W-1:0]            mul_b;
  logic                      mul_en;
  logic signed [MUL_P_W-1:0] prod;
  localparam int TERM_W = MUL_P_W - FRAC_BITS;
  logic signed [TERM_W-1:0]  term;
  logic [VALUE_WIDTH-1:0]    est_upd;
  logic [VALUE_WIDTH-1:0]    cov_upd;
  logic [VALUE_WIDTH-1:0]    res_val;
  logic [TDATA_W-1:0]        out_pack;
  logic                      in_acc;
  logic                      out_load;
  logic                      last_ch;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign last_ch    = (ch_r == CH_W'(NCHAN - 1));

  assign sum_cur   = sum_r[ch_r];
  assign est_cur   = est_r[ch_r];
  assign cov_cur   = cov_r[ch_r];
  assign delta_cur = delta_r[ch_r];

  // running trajectory, saturating
  assign sum_add = sat_v(sext_w(sum_cur) + sext_w(delta_cur));

  // predicted covariance P + Q, clamped to the largest positive value
  assign pp_raw = {1'b0, cov_cur} + {2'b00, q_r};
  assign pp_sat = (pp_raw[VALUE_WIDTH] || pp_raw[VALUE_WIDTH-1]) ? V_MAX
                                                                 : pp_raw[VALUE_WIDTH-1:0];

  // gain divider: K = Pp / (Pp + R)
  assign div_req.start = (state_r == S_KICK);
  assign div_req.num   = pp_r;
  assign div_req.den   = {1'b0, pp_r} + {2'b00, r_r};

  kts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // shared multiplier: first K * (sum - x), then (1 - K) * Pp
  assign diff   = $signed({sum_cur[VALUE_WIDTH-1], sum_cur})
                - $signed({est_cur[VALUE_WIDTH-1], est_cur});
  assign mul_en = (state_r == S_MUL1) || (state_r == S_MUL2);
  assign mul_a  = (state_r == S_MUL1) ? diff : $signed({1'b0, pp_r});
  assign mul_b  = (state_r == S_MUL1) ? k_r : (K_ONE - k_r);

  kts_mul u_mul (
    .clk    (clk),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // floor of the product down to FRAC_BITS fraction bits
  assign term    = prod[MUL_P_W-1:FRAC_BITS];
  assign est_upd = sat_v(sext_w(est_cur) + {{(WIDE_W-TERM_W){term[TERM_W-1]}}, term});
  assign cov_upd = prod[FRAC_BITS +: VALUE_WIDTH];

  // result: delta + (estimate - sum)
  assign res_val = sat_v(sext_w(delta_cur) + sext_w(est_cur) - sext_w(sum_cur));

  always_comb begin
    out_pack = '0;
    for (int c = 0; c < NCHAN; c++) begin
      out_pack[c*VALUE_WIDTH +: VALUE_WIDTH] = res_r[c];
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SUM;
          ch_nxt    = '0;
        end
      end
      S_SUM:  state_nxt = first_r ? S_RES : S_KICK;
      S_KICK: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_RES;
      S_RES: begin
        if (last_ch) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SUM;
          ch_nxt    = ch_r + CH_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ch_r         <= '0;
      first_r      <= 1'b1;
      out_tvalid_r <= 1'b0;
      for (int c = 0; c < NCHAN; c++) begin
        sum_r[c] <= '0;
        est_r[c] <= '0;
        cov_r[c] <= P_RESET;
      end
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        first_r      <= 1'b0;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_SUM:   sum_r[ch_r] <= sum_add;
        S_MUL2:  est_r[ch_r] <= est_upd;
        S_MUL3:  cov_r[ch_r] <= cov_upd;
        default: ;
      endcase
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= Q_RESET;
      r_r <= R_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROCESS_NOISE: q_r <= cfg_wdata;
        REG_MEAS_NOISE:    r_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < NCHAN; c++) begin
        delta_r[c] <= in_tdata[c*VALUE_WIDTH +: VALUE_WIDTH];
      end
    end
    if (state_r == S_SUM) begin
      pp_r <= pp_sat;
    end
    if ((state_r == S_DIVW) && div_rsp.done) begin
      k_r <= div_rsp.quot;
    end
    if (state_r == S_RES) begin
      res_r[ch_r] <= res_val;
    end
    if (out_load) begin
      out_tdata_r <= out_pack;
    end
  end

  // covariance stays non-negative
  a_cov_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !cov_r[ch_r][VALUE_WIDTH-1])
    else $error("covariance went negative");

  // gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL1) |-> (k_r <= K_ONE))
    else $error("gain above one");

  // an accepted word starts at channel 0
  a_start_ch0: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SUM) && (ch_r == '0))
    else $error("word not started at first channel");

  // a result only appears after the last channel is done
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  // the divider reports back only while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIVW))
    else $error("divider finished out of turn");

endmodule

`default_nettype wire

// ===== hdl/kts_div.sv =====
`default_nettype none

// restoring divider for the gain, one quotient bit a cycle
module kts_div import kts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(FRAC_BITS);

  logic             busy_r;
  logic             chk_r;
  logic             done_r;
  logic [REM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [K_W-1:0]   quot_r;
  logic [CNT_W-1:0] cnt_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] den_ext;
  logic [REM_W-1:0] rem_sub;
  logic             take;
  logic             den_zero;
  logic             sat_one;

  assign den_ext  = {1'b0, den_r};
  assign rem_sh   = {rem_r[REM_W-2:0], 1'b0};
  assign rem_sub  = rem_sh - den_ext;
  assign take     = (rem_sh >= den_ext);
  assign den_zero = (den_r == '0);
  assign sat_one  = (rem_r >= den_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        chk_r  <= 1'b1;
      end else if (busy_r) begin
        if (chk_r) begin
          chk_r <= 1'b0;
          if (den_zero || sat_one) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r  <= REM_W'(req_i.num);
      den_r  <= req_i.den;
      quot_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (chk_r) begin
        if (den_zero) begin
          quot_r <= '0;
        end else if (sat_one) begin
          quot_r <= K_ONE;
        end
      end else begin
        rem_r  <= take ? rem_sub : rem_sh;
        quot_r <= {quot_r[K_W-2:0], take};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quot = quot_r;

endmodule

`default_nettype wire

// ===== hdl/kts_mul.sv =====
`default_nettype none

// shared signed x unsigned-gain multiplier, registered product
module kts_mul import kts_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      en_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic [K_W-1:0]            b_i,
  output logic signed [MUL_P_W-1:0]      prod_o
);

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      prod_r <= MUL_P_W'(a_i) * MUL_P_W'($signed({1'b0, b_i}));
    end
  end

  assign prod_o = prod_r;

endmodule

`default_nettype wire
